// File: rtl/core/ccd_pkg.sv
// ============================================================================
// ccd_pkg - shared types and constant tables of the cyrillic code page detector
// Letter weights, the cp855 upper-half table and the constants for the
// incremental 10/13 scaling of the maccyrillic score.
// ============================================================================
package ccd_pkg;

    localparam int unsigned PAGE_COUNT   = 5;
    localparam int unsigned LETTER_COUNT = 32;
    localparam int unsigned SCORE_W      = 32;
    localparam int unsigned WEIGHT_W     = 14;
    localparam int unsigned REM_W        = 4;
    localparam int unsigned INDEX_W      = 3;

    // page codes, as reported on the output
    localparam logic [INDEX_W-1:0] PAGE_866   = 3'd0;
    localparam logic [INDEX_W-1:0] PAGE_855   = 3'd1;
    localparam logic [INDEX_W-1:0] PAGE_1251  = 3'd2;
    localparam logic [INDEX_W-1:0] PAGE_MAC   = 3'd3;
    localparam logic [INDEX_W-1:0] PAGE_ISO   = 3'd4;

    localparam int unsigned SCALE_NUM = 10;
    localparam int unsigned SCALE_DEN = 13;

    typedef struct packed {
        logic       hit;
        logic [4:0] letter;
    } letter_hit_t;

    typedef letter_hit_t [PAGE_COUNT-1:0] page_hits_t;

    typedef logic [WEIGHT_W-1:0] weight_tab_t [LETTER_COUNT];
    typedef logic [REM_W-1:0]    rem_tab_t    [LETTER_COUNT];

    localparam weight_tab_t LETTER_WEIGHT = '{
        14'd7998, 14'd1592, 14'd4533, 14'd1687, 14'd2977, 14'd8483, 14'd940,  14'd1641,
        14'd7367, 14'd1208, 14'd3486, 14'd4343, 14'd3203, 14'd6700, 14'd10983, 14'd2804,
        14'd4746, 14'd5473, 14'd6318, 14'd2615, 14'd267,  14'd966,  14'd486,  14'd1450,
        14'd718,  14'd361,  14'd37,   14'd1898, 14'd1735, 14'd331,  14'd639,  14'd2001
    };

    // cp855 upper half: bit 5 marks a basic letter, bits 4:0 its index
    localparam logic [7:0] CP855_ROM [128] = '{
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd62, 8'd62, 8'd58, 8'd58,
        8'd32, 8'd32, 8'd33, 8'd33, 8'd54, 8'd54, 8'd36, 8'd36,
        8'd37, 8'd37, 8'd52, 8'd52, 8'd35, 8'd35, 8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd53, 8'd53, 8'd40,
        8'd40, 8'd0,  8'd0,  8'd0,  8'd0,  8'd41, 8'd41, 8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd42, 8'd42,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd43, 8'd43, 8'd44, 8'd44, 8'd45, 8'd45, 8'd46, 8'd46,
        8'd47, 8'd0,  8'd0,  8'd0,  8'd0,  8'd47, 8'd63, 8'd0,
        8'd63, 8'd48, 8'd48, 8'd49, 8'd49, 8'd50, 8'd50, 8'd51,
        8'd51, 8'd38, 8'd38, 8'd34, 8'd34, 8'd60, 8'd60, 8'd0,
        8'd0,  8'd59, 8'd59, 8'd39, 8'd39, 8'd56, 8'd56, 8'd61,
        8'd61, 8'd57, 8'd57, 8'd55, 8'd55, 8'd0,  8'd0,  8'd0
    };

    function automatic weight_tab_t build_mac_quo();
        weight_tab_t t;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            t[i] = WEIGHT_W'((32'(LETTER_WEIGHT[i]) * SCALE_NUM) / SCALE_DEN);
        end
        return t;
    endfunction

    function automatic rem_tab_t build_mac_rem();
        rem_tab_t t;
        for (int i = 0; i < LETTER_COUNT; i++) begin
            t[i] = REM_W'((32'(LETTER_WEIGHT[i]) * SCALE_NUM) % SCALE_DEN);
        end
        return t;
    endfunction

    // 10*w split into quotient and remainder by 13, per letter
    localparam weight_tab_t MAC_QUO = build_mac_quo();
    localparam rem_tab_t    MAC_REM = build_mac_rem();

    localparam longint unsigned MAC_SAT_PROD = 64'hFFFF_FFFF * 64'd10;
    localparam logic [SCORE_W-1:0] MAC_SAT_QUO = SCORE_W'(MAC_SAT_PROD / SCALE_DEN);
    localparam logic [REM_W-1:0]   MAC_SAT_REM = REM_W'(MAC_SAT_PROD % SCALE_DEN);

endpackage

// File: rtl/core/ccd_letter_decode.sv
// ============================================================================
// ccd_letter_decode - high byte to letter index in each code page
// Flags, per page, whether the byte is a basic cyrillic letter and which one.
// ============================================================================
module ccd_letter_decode
    import ccd_pkg::*;
(
    input  logic [7:0] text_byte,
    output page_hits_t hits
);

    logic [7:0] cp855_entry;

    assign cp855_entry = CP855_ROM[text_byte[6:0]];

    always_comb
    begin
        hits = '0;
        if (text_byte[7])
        begin
            // 866: 80..af and e0..ef
            if (text_byte <= 8'hAF)
            begin
                hits[PAGE_866] = '{hit: 1'b1, letter: text_byte[4:0]};
            end
            else if (text_byte >= 8'hE0 && text_byte <= 8'hEF)
            begin
                hits[PAGE_866] = '{hit: 1'b1, letter: {1'b1, text_byte[3:0]}};
            end

            hits[PAGE_855] = '{hit: cp855_entry[5], letter: cp855_entry[4:0]};

            // 1251: c0..ff
            if (text_byte >= 8'hC0)
            begin
                hits[PAGE_1251] = '{hit: 1'b1, letter: text_byte[4:0]};
            end

            // maccyrillic: 80..9f, df (small ya), e0..fe
            if (text_byte <= 8'h9F || text_byte == 8'hDF ||
                (text_byte >= 8'hE0 && text_byte <= 8'hFE))
            begin
                hits[PAGE_MAC] = '{hit: 1'b1, letter: text_byte[4:0]};
            end

            // iso 8859-5: b0..ef, offset from b0 folded to 5 bits
            if (text_byte >= 8'hB0 && text_byte <= 8'hEF)
            begin
                hits[PAGE_ISO] = '{hit: 1'b1, letter: {~text_byte[4], text_byte[3:0]}};
            end
        end
    end

endmodule

// File: rtl/core/cyrillic_codepage_detector_top.sv
// ============================================================================
// cyrillic_codepage_detector_top - letter frequency code page detector
// Scores a byte stream against five cyrillic code pages and reports the
// best one when the last byte of a text arrives.
// ============================================================================
//
//  channel | dir | tdata fields (low bit up)              | sideband
//  --------+-----+-----------------------------------------+------------------
//  s_*     | in  | text_byte[7:0]                          | tlast=end_of_text
//  m_*     | out | page_index[2:0], best_score[34:3], pad  | none
//
//  one byte transaction is taken every cycle unless a last byte waits on
//  a full snapshot stage; scores are registered in the score stage through
//  the decode plus saturating add. a last byte reaches m_tvalid through the
//  snapshot and result registers. reset clears the running scores and all
//  valids. a stalled result holds; the snapshot and input stages keep
//  taking bytes until a second last byte would need the snapshot stage.
//
module cyrillic_codepage_detector_top
    import ccd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // text_byte[7:0]
    input  logic        s_tlast,    // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata     // page_index[2:0], best_score[34:3], zero[39:35]
);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // running scores; page 3 also keeps its 10/13 scaled value and remainder
    logic [SCORE_W-1:0] score_reg [PAGE_COUNT];
    logic [SCORE_W-1:0] score_next [PAGE_COUNT];
    logic [SCORE_W-1:0] mac_quo_reg, mac_quo_next;
    logic [REM_W-1:0]   mac_rem_reg, mac_rem_next;

    // snapshot of the final scaled scores of a text
    logic               snap_valid_reg;
    logic [SCORE_W-1:0] snap_reg [PAGE_COUNT];

    // result register
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;

    logic       out_free;
    logic       snap_free;
    logic       in_proc;
    logic       in_free;
    page_hits_t hits;

    // stage flow: each stage moves when the one after it has room; only a last byte needs the snapshot stage
    assign out_free  = !out_valid_reg || m_tready;
    assign snap_free = !snap_valid_reg || out_free;
    assign in_proc   = in_valid_reg && (!in_last_reg || snap_free);
    assign in_free   = !in_valid_reg || in_proc;
    assign s_tready  = in_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_free)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_free && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ccd_letter_decode u_decode (
        .text_byte (in_byte_reg),
        .hits      (hits)
    );

    // saturating score update for every page
    always_comb
    begin
        logic [SCORE_W:0]  sum;
        logic [REM_W:0]    rem_sum;
        logic              rem_carry;
        logic [SCORE_W:0]  mac_sum;

        for (int p = 0; p < PAGE_COUNT; p++)
        begin
            sum = {1'b0, score_reg[p]} + (SCORE_W+1)'(LETTER_WEIGHT[hits[p].letter]);
            if (!hits[p].hit)
            begin
                score_next[p] = score_reg[p];
            end
            else if (sum[SCORE_W])
            begin
                score_next[p] = '1;
            end
            else
            begin
                score_next[p] = sum[SCORE_W-1:0];
            end
        end

        // scaled mac score kept as quotient and remainder of 10*score by 13
        mac_sum   = {1'b0, score_reg[PAGE_MAC]}
                  + (SCORE_W+1)'(LETTER_WEIGHT[hits[PAGE_MAC].letter]);
        rem_sum   = (REM_W+1)'(mac_rem_reg) + (REM_W+1)'(MAC_REM[hits[PAGE_MAC].letter]);
        rem_carry = (rem_sum >= (REM_W+1)'(SCALE_DEN));
        if (!hits[PAGE_MAC].hit)
        begin
            mac_quo_next = mac_quo_reg;
            mac_rem_next = mac_rem_reg;
        end
        else if (mac_sum[SCORE_W])
        begin
            mac_quo_next = MAC_SAT_QUO;
            mac_rem_next = MAC_SAT_REM;
        end
        else
        begin
            mac_quo_next = mac_quo_reg + SCORE_W'(MAC_QUO[hits[PAGE_MAC].letter])
                         + SCORE_W'(rem_carry);
            mac_rem_next = rem_carry ? REM_W'(rem_sum - (REM_W+1)'(SCALE_DEN))
                                     : rem_sum[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAGE_COUNT; p++)
            begin
                score_reg[p] <= '0;
            end
            mac_quo_reg <= '0;
            mac_rem_reg <= '0;
        end
        else if (in_proc)
        begin
            // a last byte hands its scores to the snapshot and starts afresh
            for (int p = 0; p < PAGE_COUNT; p++)
            begin
                score_reg[p] <= in_last_reg ? '0 : score_next[p];
            end
            mac_quo_reg <= in_last_reg ? '0 : mac_quo_next;
            mac_rem_reg <= in_last_reg ? '0 : mac_rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else if (in_proc && in_last_reg)
        begin
            snap_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            snap_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_proc && in_last_reg)
        begin
            for (int p = 0; p < PAGE_COUNT; p++)
            begin
                snap_reg[p] <= (p == int'(PAGE_MAC)) ? mac_quo_next : score_next[p];
            end
        end
    end

    // highest score, ties to the lower page: the lower side wins unless beaten
    always_comb
    begin
        logic [INDEX_W-1:0] idx_a, idx_b, idx_ab;
        logic [SCORE_W-1:0] val_a, val_b, val_ab;

        idx_a = (snap_reg[1] > snap_reg[0]) ? PAGE_855 : PAGE_866;
        val_a = (snap_reg[1] > snap_reg[0]) ? snap_reg[1] : snap_reg[0];
        idx_b = (snap_reg[3] > snap_reg[2]) ? PAGE_MAC : PAGE_1251;
        val_b = (snap_reg[3] > snap_reg[2]) ? snap_reg[3] : snap_reg[2];
        idx_ab = (val_b > val_a) ? idx_b : idx_a;
        val_ab = (val_b > val_a) ? val_b : val_a;
        if (snap_reg[4] > val_ab)
        begin
            out_index_next = PAGE_ISO;
            out_score_next = snap_reg[4];
        end
        else
        begin
            out_index_next = idx_ab;
            out_score_next = val_ab;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= snap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && snap_valid_reg)
        begin
            out_index_reg <= out_index_next;
            out_score_reg <= out_score_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_score_reg, out_index_reg};

endmodule

// File: rtl/core/ccd_checker.sv
// ============================================================================
// ccd_checker - port level checks of the code page detector
// Watches the stream ports of the top level; attached by bind.
// ============================================================================
module ccd_checker
    import ccd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // stalled result transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // with no result pending nothing can hold back the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // winner is a real page and padding stays zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= PAGE_ISO && m_tdata[39:35] == 5'b0)
        else $error("bad page index or padding");

    // all-zero scores tie, so the lowest page must win
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[34:3] == 32'd0 |-> m_tdata[2:0] == PAGE_866)
        else $error("zero score not reported on first page");

endmodule

bind cyrillic_codepage_detector_top ccd_checker u_ccd_checker (.*);

// File: dv/ccd_verdict_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// ccd_verdict_checker - code page verdict predictor and comparator
// Watches both stream channels of the cyrillic code page detector, scores
// every accepted text byte against its own code page tables and checks each
// reported page index and best score against the oldest predicted verdict.
// ============================================================================
module ccd_verdict_checker
    import ccd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [7:0]        s_tdata,
    input  logic              s_tlast,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [39:0]       m_tdata,
    output int unsigned       error_count,
    output int unsigned       verdicts_pending
);

    localparam longint unsigned MAC_NUM = 10;
    localparam longint unsigned MAC_DEN = 13;

    typedef struct packed {
        logic [INDEX_W-1:0] page;
        logic [SCORE_W-1:0] score;
    } verdict_t;

    // frequency weight per basic letter, a..ya
    localparam logic [13:0] FREQ_WEIGHT [32] = '{
        14'd7998, 14'd1592, 14'd4533, 14'd1687, 14'd2977, 14'd8483, 14'd940,   14'd1641,
        14'd7367, 14'd1208, 14'd3486, 14'd4343, 14'd3203, 14'd6700, 14'd10983, 14'd2804,
        14'd4746, 14'd5473, 14'd6318, 14'd2615, 14'd267,  14'd966,  14'd486,   14'd1450,
        14'd718,  14'd361,  14'd37,   14'd1898, 14'd1735, 14'd331,  14'd639,   14'd2001
    };

    // cp855 upper half: bit 5 = basic letter, bits 4:0 = letter
    localparam logic [7:0] CP855_LETTER [128] = '{
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd62, 8'd62, 8'd58, 8'd58,
        8'd32, 8'd32, 8'd33, 8'd33, 8'd54, 8'd54, 8'd36, 8'd36,
        8'd37, 8'd37, 8'd52, 8'd52, 8'd35, 8'd35, 8'd0,  8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd53, 8'd53, 8'd40,
        8'd40, 8'd0,  8'd0,  8'd0,  8'd0,  8'd41, 8'd41, 8'd0,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd42, 8'd42,
        8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
        8'd43, 8'd43, 8'd44, 8'd44, 8'd45, 8'd45, 8'd46, 8'd46,
        8'd47, 8'd0,  8'd0,  8'd0,  8'd0,  8'd47, 8'd63, 8'd0,
        8'd63, 8'd48, 8'd48, 8'd49, 8'd49, 8'd50, 8'd50, 8'd51,
        8'd51, 8'd38, 8'd38, 8'd34, 8'd34, 8'd60, 8'd60, 8'd0,
        8'd0,  8'd59, 8'd59, 8'd39, 8'd39, 8'd56, 8'd56, 8'd61,
        8'd61, 8'd57, 8'd57, 8'd55, 8'd55, 8'd0,  8'd0,  8'd0
    };

    logic [SCORE_W-1:0] text_score [PAGE_COUNT];
    verdict_t           verdict_q [$];
    verdict_t           due;
    int unsigned        mismatches;

    // {hit, letter} of a high byte in one code page
    function automatic logic [5:0] page_letter(input logic [INDEX_W-1:0] page,
                                               input logic [7:0] b);
        logic [7:0] e;
        e = CP855_LETTER[b[6:0]];
        case (page)
            PAGE_866:
                if (b >= 8'h80 && b <= 8'hAF)      return {1'b1, 5'(b - 8'h80)};
                else if (b >= 8'hE0 && b <= 8'hEF) return {1'b1, 5'(b - 8'hE0) + 5'd16};
            PAGE_855:
                if (e[5])                          return {1'b1, e[4:0]};
            PAGE_1251:
                if (b >= 8'hC0)                    return {1'b1, 5'(b - 8'hC0)};
            PAGE_MAC:
                if (b >= 8'h80 && b <= 8'h9F)      return {1'b1, 5'(b - 8'h80)};
                else if (b == 8'hDF)               return {1'b1, 5'd31};
                else if (b >= 8'hE0 && b <= 8'hFE) return {1'b1, 5'(b - 8'hE0)};
            default:
                if (b >= 8'hB0 && b <= 8'hEF)      return {1'b1, 5'(b - 8'hB0)};
        endcase
        return 6'd0;
    endfunction

    task automatic score_text_byte(input logic [7:0] b);
        logic [5:0]         hit;
        logic [SCORE_W:0]   sum;
        if (b[7])
        begin
            for (int p = 0; p < PAGE_COUNT; p++)
            begin
                hit = page_letter(INDEX_W'(p), b);
                if (hit[5])
                begin
                    sum = {1'b0, text_score[p]} + FREQ_WEIGHT[hit[4:0]];
                    // saturate at all ones
                    text_score[p] = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
                end
            end
        end
    endtask

    // mac score scaled by 10/13 with a wide product, lowest index wins ties
    function automatic verdict_t pick_page();
        logic [SCORE_W-1:0] scaled [PAGE_COUNT];
        verdict_t           v;
        for (int p = 0; p < PAGE_COUNT; p++)
            scaled[p] = text_score[p];
        scaled[PAGE_MAC] = SCORE_W'((longint'(text_score[PAGE_MAC]) * MAC_NUM) / MAC_DEN);
        v.page  = PAGE_866;
        v.score = scaled[0];
        for (int p = 1; p < PAGE_COUNT; p++)
        begin
            if (scaled[p] > v.score)
            begin
                v.page  = INDEX_W'(p);
                v.score = scaled[p];
            end
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAGE_COUNT; p++)
                text_score[p] = '0;
            verdict_q.delete();
            mismatches = 0;
            error_count      <= 0;
            verdicts_pending <= 0;
        end
        else
        begin
            // verdict transaction: a result never leaves in its own byte's cycle
            if (m_tvalid && m_tready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected verdict: page_index %0d best_score %0d",
                           m_tdata[2:0], m_tdata[34:3]);
                    mismatches++;
                end
                else
                begin
                    due = verdict_q.pop_front();
                    if (m_tdata[2:0] !== due.page)
                    begin
                        $error("page_index mismatch: expected %0d, actual %0d",
                               due.page, m_tdata[2:0]);
                        mismatches++;
                    end
                    if (m_tdata[34:3] !== due.score)
                    begin
                        $error("best_score mismatch: expected %0d, actual %0d",
                               due.score, m_tdata[34:3]);
                        mismatches++;
                    end
                end
            end
            // text byte transaction
            if (s_tvalid && s_tready)
            begin
                score_text_byte(s_tdata);
                if (s_tlast)
                begin
                    verdict_q.push_back(pick_page());
                    for (int p = 0; p < PAGE_COUNT; p++)
                        text_score[p] = '0;
                end
            end
            error_count      <= mismatches;
            verdicts_pending <= verdict_q.size();
        end
    end

endmodule

// File: dv/tb_cyrillic_codepage_detector_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_cyrillic_codepage_detector_top - stream testbench of the code page detector
// Feeds directed and random texts through the byte stream under three idling
// schemes; a separate checker predicts every verdict and compares it on the
// result stream.
// ============================================================================
module tb_cyrillic_codepage_detector_top;

    localparam int unsigned STALL_LIMIT    = 5000;    // cycles with no transaction at all
    localparam int unsigned DRAIN_CYCLES   = 12;
    localparam int unsigned RANDOM_BYTES   = 1750;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // text_byte[7:0]
    logic        s_tlast = 1'b0;     // end_of_text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // page_index[2:0], best_score[34:3], zero[39:35]

    int unsigned error_count;
    int unsigned verdicts_pending;
    int unsigned send_gap_pct = 36;
    int unsigned recv_gap_pct = 65;
    int unsigned bytes_sent = 0;
    int unsigned texts_sent = 0;
    int unsigned random_sent = 0;
    int unsigned quiet_cycles = 0;
    logic [7:0]  text_q [$];

    cyrillic_codepage_detector_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ccd_verdict_checker u_verdict_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .error_count      (error_count),
        .verdicts_pending (verdicts_pending)
    );

    always #5 clk = ~clk;

    // receiver backpressure, one fresh decision per cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_gap_pct);

    // watchdog: a run that stops moving on both channels is hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("tb_cyrillic_codepage_detector_top: errors");
                $finish;
            end
        end
    end

    // one byte transaction, with random idle cycles ahead of it; valid stays
    // high from one byte to the next unless a gap is drawn
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
        if (last)
            texts_sent++;
    endtask

    // sends text_q as one text, end_of_text on its final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1);
        random_sent += 0;
    endtask

    // random text: mostly cyrillic-range bytes, some mixed, some pure ascii
    task automatic random_text();
        int unsigned len;
        int unsigned kind;
        kind = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(24, 1);
        text_q.delete();
        for (int i = 0; i < len; i++)
        begin
            if (kind < 10)
                text_q.push_back(8'($urandom_range(127)));
            else if (kind < 75 || $urandom_range(4) != 0)
                text_q.push_back(8'($urandom_range(255, 128)));
            else
                text_q.push_back(8'($urandom_range(255)));
        end
        send_text();
        random_sent += len;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed texts, sender 36 / receiver 65 percent idle ---
        // empty-ish texts: ascii only, all scores zero, page 866 wins at 0
        text_q = '{8'h00};                     send_text();
        text_q = '{8'h7F};                     send_text();
        // lowest and highest high byte
        text_q = '{8'h80};                     send_text();
        text_q = '{8'hFF};                     send_text();
        // one clear winner per page
        text_q = '{8'h8E};                     send_text();   // 866, heaviest letter
        text_q = '{8'hB7};                     send_text();   // 855
        text_q = '{8'hC0};                     send_text();   // 1251
        text_q = '{8'h8E, 8'hEE};              send_text();   // mac after scaling
        text_q = '{8'hB5};                     send_text();   // iso 8859-5
        // tie between 866 and 855, lower index wins
        text_q = '{8'hA0};                     send_text();
        // non-letters mixed with ascii: box drawing, yo, punctuation
        text_q = '{8'h41, 8'hB3, 8'hF0, 8'hF1, 8'h2E, 8'h0A}; send_text();
        text_q = '{8'hDF, 8'hC4, 8'h9C};       send_text();

        // --- random texts under three idling schemes ---
        while (random_sent < RANDOM_BYTES / 3)
            random_text();
        send_gap_pct = 65;
        recv_gap_pct = 36;
        while (random_sent < 2 * RANDOM_BYTES / 3)
            random_text();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        while (random_sent < RANDOM_BYTES)
            random_text();

        s_tvalid <= 1'b0;
        @(posedge clk);
        // the watchdog bounds this wait
        while (verdicts_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d texts with %0d bytes, directed page winners, ties and ascii",
                 texts_sent, bytes_sent);
        $display("idling: sender 36 / receiver 65, then 65 / 36, then none");
        if (error_count == 0)
            $display("tb_cyrillic_codepage_detector_top: clean");
        else
            $display("tb_cyrillic_codepage_detector_top: errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/ccd_pkg.sv
rtl/core/ccd_letter_decode.sv
rtl/core/cyrillic_codepage_detector_top.sv
rtl/core/ccd_checker.sv
dv/ccd_verdict_checker.sv
dv/tb_cyrillic_codepage_detector_top.sv
